FILE: design/dmc_pkg.sv
package dmc_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_PROBE,
		ST_LAST,
		ST_DECIDE,
		ST_POP,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		EV_STARTED     = 2'd0,
		EV_ADVANCED    = 2'd1,
		EV_BACKTRACKED = 2'd2,
		EV_FINISHED    = 2'd3
	} event_t;

	typedef enum logic [1:0] {
		DIR_UP    = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_RIGHT = 2'd3
	} dir_t;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_STEP  = 1'b1;

	localparam logic REG_GRID_ROWS = 1'b0;
	localparam logic REG_GRID_COLS = 1'b1;

	typedef logic [3:0][1:0] dir_order_t;

	typedef struct packed {
		logic [6:0] wr;
		logic [6:0] wc;
	} wall_t;

	typedef struct packed {
		logic hit;
		dir_t code;
	} choice_t;

	// Three-swap Fisher-Yates ordering of the four direction codes.
	function automatic dir_order_t shuffle(logic [1:0] p0, logic [1:0] p1, logic p2);
		dir_order_t o;
		logic [1:0] pk [3];
		logic [1:0] t;
		o[0] = 2'd0;
		o[1] = 2'd1;
		o[2] = 2'd2;
		o[3] = 2'd3;
		pk[0] = p0;
		pk[1] = (p1 == 2'd3) ? 2'd3 : p1 + 2'd1;
		pk[2] = {1'b1, p2};
		for (int i = 0; i < 3; i++) begin
			t = o[i];
			o[i] = o[pk[i]];
			o[pk[i]] = t;
		end
		return o;
	endfunction

	// Tries the codes in order. A visited neighbour passes the try on to the next
	// higher code, and one outside the grid ends the try.
	function automatic choice_t choose(dir_order_t o, logic [3:0] inb, logic [3:0] vis);
		choice_t ch;
		logic live;
		ch.hit = 1'b0;
		ch.code = DIR_UP;
		for (int i = 0; i < 4; i++) begin
			live = 1'b1;
			for (int c = 0; c < 4; c++) begin
				if (!ch.hit && live && (c >= int'(o[i]))) begin
					if (!inb[c]) begin
						live = 1'b0;
					end else if (!vis[c]) begin
						ch.hit = 1'b1;
						ch.code = dir_t'(c[1:0]);
					end
				end
			end
		end
		return ch;
	endfunction

endpackage

FILE: design/dmc_ram.sv
module dmc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/dmc_nbr.sv
module dmc_nbr #(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 32
) (
	input  logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0] cur_row,
	input  logic [(MAX_COLS > 1 ? $clog2(MAX_COLS) : 1)-1:0] cur_col,
	input  logic [($clog2(MAX_ROWS + 1) > 6 ? $clog2(MAX_ROWS + 1) : 6)-1:0] rows,
	input  logic [($clog2(MAX_COLS + 1) > 6 ? $clog2(MAX_COLS + 1) : 6)-1:0] cols,
	input  dmc_pkg::dir_t                                    code,
	output logic                                             inb,
	output logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0] nb_row,
	output logic [(MAX_COLS > 1 ? $clog2(MAX_COLS) : 1)-1:0] nb_col,
	output dmc_pkg::wall_t                                   wall,
	output logic [(MAX_ROWS * MAX_COLS > 1 ? $clog2(MAX_ROWS * MAX_COLS) : 1)-1:0] addr
);
	import dmc_pkg::*;

	localparam int RW    = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
	localparam int RDW   = $clog2(MAX_ROWS + 1) > 6 ? $clog2(MAX_ROWS + 1) : 6;
	localparam int CDW   = $clog2(MAX_COLS + 1) > 6 ? $clog2(MAX_COLS + 1) : 6;
	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int AW    = CELLS > 1 ? $clog2(CELLS) : 1;

	logic [RW+1:0] r2;
	logic [CW+1:0] c2;
	logic [RW+1:0] wr_full;
	logic [CW+1:0] wc_full;

	always_comb begin
		r2 = {1'b0, cur_row, 1'b0};
		c2 = {1'b0, cur_col, 1'b0};
		nb_row = cur_row;
		nb_col = cur_col;
		wr_full = r2 + (RW + 2)'(1);
		wc_full = c2 + (CW + 2)'(1);
		unique case (code)
			DIR_UP: begin
				inb = cur_row != '0;
				nb_row = cur_row - RW'(1);
				wr_full = r2;
			end
			DIR_DOWN: begin
				inb = (RDW'(cur_row) + RDW'(1)) < rows;
				nb_row = cur_row + RW'(1);
				wr_full = r2 + (RW + 2)'(2);
			end
			DIR_LEFT: begin
				inb = cur_col != '0;
				nb_col = cur_col - CW'(1);
				wc_full = c2;
			end
			DIR_RIGHT: begin
				inb = (CDW'(cur_col) + CDW'(1)) < cols;
				nb_col = cur_col + CW'(1);
				wc_full = c2 + (CW + 2)'(2);
			end
			default: begin
				inb = 1'b0;
			end
		endcase
		wall.wr = 7'(wr_full);
		wall.wc = 7'(wc_full);
		addr = inb ? AW'(int'(nb_row) * MAX_COLS + int'(nb_col)) : '0;
	end

endmodule

FILE: design/dfs_maze_carver.sv
// Channel  Direction  Handshake          Payload
// s_       in         s_tvalid/s_tready  tuser: req_type; tdata: start and picks
// m_       out        m_tvalid/m_tready  tuser: event_res; tdata: carved, wall, next
// cfg_     in         cfg_we             cfg_idx selects grid_rows or grid_cols
//
// A step item probes the neighbours in turn through the single read port of the
// visited map in ST_PROBE and ST_LAST, then passes ST_DECIDE, and ST_POP when it
// backtracks, before ST_OUT. A step with no walk active goes straight to ST_OUT.
// A start item sweeps the visited map one cell a cycle, over all MAX_ROWS * MAX_COLS
// cells. Reset leaves no walk active, so the map needs no pass after reset.
// An item is accepted while a finished result still waits on the output.
module dfs_maze_carver #(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [5:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// start_row, start_col, pick_first, pick_second, pick_third, zero fill
	input  logic [15:0] s_tdata,
	// req_type
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// carved_row, carved_col, wall_row, wall_col, next_row, next_col, zero fill
	output logic [39:0] m_tdata,
	// event_res
	output logic [1:0]  m_tuser
);
	import dmc_pkg::*;

	localparam int RW    = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
	localparam int RDW   = $clog2(MAX_ROWS + 1) > 6 ? $clog2(MAX_ROWS + 1) : 6;
	localparam int CDW   = $clog2(MAX_COLS + 1) > 6 ? $clog2(MAX_COLS + 1) : 6;
	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int AW    = CELLS > 1 ? $clog2(CELLS) : 1;
	localparam int CNTW  = $clog2(CELLS + 1);
	localparam int SW    = RW + CW;

	state_t state_q, state_d;

	logic [5:0] grid_rows_q, grid_cols_q;
	logic [RDW-1:0] rows_eff;
	logic [CDW-1:0] cols_eff;

	logic       req_q;
	logic [4:0] srow_q, scol_q;
	logic [1:0] pick0_q, pick1_q;
	logic       pick2_q;

	logic [RW-1:0]   cur_row_q;
	logic [CW-1:0]   cur_col_q;
	logic [CNTW-1:0] cnt_q;
	logic            done_q;
	logic [AW-1:0]   clr_q;
	dir_t            k_q;
	logic [3:0]      inb_q, vis_q;

	event_t     res_ev_q;
	logic [4:0] res_crow_q, res_ccol_q, res_nrow_q, res_ncol_q;
	wall_t      res_wall_q;

	logic        m_tvalid_q;
	logic [39:0] m_tdata_q;
	logic [1:0]  m_tuser_q;

	logic          s_acc, idle_done, clr_last, load_out, cnt_one;
	logic [RW-1:0] srow_cl;
	logic [CW-1:0] scol_cl;
	logic [AW-1:0] cur_addr;
	choice_t       choice;

	dir_t            nb_code;
	logic            nb_inb;
	logic [RW-1:0]   nb_row;
	logic [CW-1:0]   nb_col;
	wall_t           nb_wall;
	logic [AW-1:0]   nb_addr;

	logic          vm_we, vm_wdata, vm_rdata;
	logic [AW-1:0] vm_waddr;
	logic          sk_we;
	logic [AW-1:0] sk_waddr, sk_raddr;
	logic [SW-1:0] sk_wdata, sk_rdata;

	always_comb begin
		if (grid_rows_q == '0) begin
			rows_eff = RDW'(1);
		end else if (RDW'(grid_rows_q) > RDW'(MAX_ROWS)) begin
			rows_eff = RDW'(MAX_ROWS);
		end else begin
			rows_eff = RDW'(grid_rows_q);
		end
		if (grid_cols_q == '0) begin
			cols_eff = CDW'(1);
		end else if (CDW'(grid_cols_q) > CDW'(MAX_COLS)) begin
			cols_eff = CDW'(MAX_COLS);
		end else begin
			cols_eff = CDW'(grid_cols_q);
		end
	end

	assign srow_cl = (RDW'(srow_q) >= rows_eff) ? RW'(rows_eff - RDW'(1)) : RW'(srow_q);
	assign scol_cl = (CDW'(scol_q) >= cols_eff) ? CW'(cols_eff - CDW'(1)) : CW'(scol_q);
	assign cur_addr = AW'(int'(cur_row_q) * MAX_COLS + int'(cur_col_q));
	assign choice = choose(shuffle(pick0_q, pick1_q, pick2_q), inb_q, vis_q);

	assign s_acc     = s_tvalid && s_tready;
	assign idle_done = done_q || (cnt_q == '0);
	assign clr_last  = clr_q == AW'(CELLS - 1);
	assign cnt_one   = cnt_q == CNTW'(1);

	dmc_nbr #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_nbr (
		.cur_row(cur_row_q),
		.cur_col(cur_col_q),
		.rows   (rows_eff),
		.cols   (cols_eff),
		.code   (nb_code),
		.inb    (nb_inb),
		.nb_row (nb_row),
		.nb_col (nb_col),
		.wall   (nb_wall),
		.addr   (nb_addr)
	);

	dmc_ram #(
		.WIDTH(1),
		.DEPTH(CELLS)
	) u_visited (
		.clk  (clk),
		.we   (vm_we),
		.waddr(vm_waddr),
		.wdata(vm_wdata),
		.raddr(nb_addr),
		.rdata(vm_rdata)
	);

	dmc_ram #(
		.WIDTH(SW),
		.DEPTH(CELLS)
	) u_stack (
		.clk  (clk),
		.we   (sk_we),
		.waddr(sk_waddr),
		.wdata(sk_wdata),
		.raddr(sk_raddr),
		.rdata(sk_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					if (s_tuser[0] == REQ_START) begin
						state_d = ST_CLEAR;
					end else if (idle_done) begin
						state_d = ST_OUT;
					end else begin
						state_d = ST_PROBE;
					end
				end
			end
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_OUT;
				end
			end
			ST_PROBE: begin
				if (k_q == DIR_RIGHT) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (choice.hit || cnt_one) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_POP;
				end
			end
			ST_POP: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready = state_q == ST_IDLE;
		load_out = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);
		nb_code  = (state_q == ST_DECIDE) ? choice.code : k_q;
		vm_we    = 1'b0;
		vm_waddr = cur_addr;
		vm_wdata = 1'b1;
		sk_we    = 1'b0;
		sk_waddr = AW'(cnt_q);
		sk_wdata = {nb_row, nb_col};
		sk_raddr = AW'(cnt_q - CNTW'(2));
		unique case (state_q)
			ST_CLEAR: begin
				vm_we    = 1'b1;
				vm_waddr = clr_q;
				vm_wdata = 1'b0;
				sk_we    = clr_last;
				sk_waddr = '0;
				sk_wdata = {srow_cl, scol_cl};
			end
			ST_PROBE: begin
				vm_we = k_q == DIR_UP;
			end
			ST_DECIDE: begin
				sk_we = choice.hit && (cnt_q < CNTW'(CELLS));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			grid_rows_q <= 6'd8;
			grid_cols_q <= 6'd8;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			cnt_q       <= '0;
			done_q      <= 1'b1;
			clr_q       <= '0;
			k_q         <= DIR_UP;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_idx == REG_GRID_ROWS) begin
					grid_rows_q <= cfg_data;
				end else begin
					grid_cols_q <= cfg_data;
				end
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					clr_q <= '0;
					k_q   <= DIR_UP;
					if (s_acc && (s_tuser[0] == REQ_STEP) && idle_done) begin
						done_q <= 1'b1;
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_last) begin
						cur_row_q <= srow_cl;
						cur_col_q <= scol_cl;
						cnt_q     <= CNTW'(1);
						done_q    <= 1'b0;
					end
				end
				ST_PROBE: begin
					k_q <= dir_t'(k_q + 2'd1);
				end
				ST_DECIDE: begin
					if (choice.hit) begin
						cur_row_q <= nb_row;
						cur_col_q <= nb_col;
						if (cnt_q < CNTW'(CELLS)) begin
							cnt_q <= cnt_q + CNTW'(1);
						end
					end else begin
						cnt_q <= cnt_q - CNTW'(1);
						if (cnt_one) begin
							done_q <= 1'b1;
						end
					end
				end
				ST_POP: begin
					cur_row_q <= sk_rdata[SW-1:CW];
					cur_col_q <= sk_rdata[CW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			req_q   <= s_tuser[0];
			srow_q  <= s_tdata[4:0];
			scol_q  <= s_tdata[9:5];
			pick0_q <= s_tdata[11:10];
			pick1_q <= s_tdata[13:12];
			pick2_q <= s_tdata[14];
		end
		if ((state_q == ST_IDLE) && s_acc && (s_tuser[0] == REQ_STEP) && idle_done) begin
			res_ev_q   <= EV_FINISHED;
			res_crow_q <= '0;
			res_ccol_q <= '0;
			res_wall_q <= '0;
			res_nrow_q <= 5'(cur_row_q);
			res_ncol_q <= 5'(cur_col_q);
		end
		if ((state_q == ST_CLEAR) && clr_last && (req_q == REQ_START)) begin
			res_ev_q   <= EV_STARTED;
			res_crow_q <= '0;
			res_ccol_q <= '0;
			res_wall_q <= '0;
			res_nrow_q <= 5'(srow_cl);
			res_ncol_q <= 5'(scol_cl);
		end
		if (state_q == ST_PROBE) begin
			inb_q[k_q] <= nb_inb;
			if (k_q != DIR_UP) begin
				vis_q[k_q - 2'd1] <= vm_rdata;
			end
		end
		if (state_q == ST_LAST) begin
			vis_q[3] <= vm_rdata;
		end
		if (state_q == ST_DECIDE) begin
			res_crow_q <= 5'(cur_row_q);
			res_ccol_q <= 5'(cur_col_q);
			if (choice.hit) begin
				res_ev_q   <= EV_ADVANCED;
				res_wall_q <= nb_wall;
				res_nrow_q <= 5'(nb_row);
				res_ncol_q <= 5'(nb_col);
			end else begin
				res_ev_q   <= EV_FINISHED;
				res_wall_q <= '0;
				res_nrow_q <= 5'(cur_row_q);
				res_ncol_q <= 5'(cur_col_q);
			end
		end
		if (state_q == ST_POP) begin
			res_ev_q   <= EV_BACKTRACKED;
			res_nrow_q <= 5'(sk_rdata[SW-1:CW]);
			res_ncol_q <= 5'(sk_rdata[CW-1:0]);
		end
		if (load_out) begin
			m_tdata_q <= {6'd0, res_ncol_q, res_nrow_q, res_wall_q.wc, res_wall_q.wr,
				res_ccol_q, res_crow_q};
			m_tuser_q <= res_ev_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

FILE: design/dmc_checker.sv
module dmc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import dmc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Stalled result item changed or vanished.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("Ready stayed high after an item was accepted.");

	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("Result item appeared without an item being worked on.");

	a_wall_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != EV_ADVANCED) |-> m_tdata[23:10] == 14'd0)
		else $error("Wall fields set on a result that did not advance.");

	a_start_carved_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == EV_STARTED) |-> m_tdata[9:0] == 10'd0)
		else $error("Carved fields set on a start result.");

endmodule

bind dfs_maze_carver dmc_checker u_dmc_checker (.*);

FILE: bench/maze_walk_checker.sv
`timescale 1ns / 100ps
module maze_walk_checker #(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [5:0]  cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic [0:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic [1:0]  m_tuser,
	output int          outstanding,
	output int          errors
);
	import dmc_pkg::*;

	localparam int CELLS = MAX_ROWS * MAX_COLS;

	typedef struct packed {
		event_t     ev;
		logic [4:0] carved_row;
		logic [4:0] carved_col;
		logic [6:0] wall_row;
		logic [6:0] wall_col;
		logic [4:0] next_row;
		logic [4:0] next_col;
	} carve_t;

	logic       seen [CELLS];
	int         trail [CELLS];
	int         trail_len;
	int         at_row;
	int         at_col;
	logic       walk_idle;
	logic [5:0] rows_reg;
	logic [5:0] cols_reg;
	carve_t     expected_q [$];

	function automatic int span(logic [5:0] v, int limit);
		if (v == 0) return 1;
		if (int'(v) > limit) return limit;
		return int'(v);
	endfunction

	function automatic carve_t carve_step(logic kind, logic [15:0] data);
		carve_t res;
		int rows, cols, r, c, nr, nc, wr, wc, code, t;
		int order [4];
		int pk [3];
		logic inb, hit;
		res = '0;
		rows = span(rows_reg, MAX_ROWS);
		cols = span(cols_reg, MAX_COLS);
		if (kind == REQ_START) begin
			r = int'(data[4:0]);
			c = int'(data[9:5]);
			if (r >= rows) r = rows - 1;
			if (c >= cols) c = cols - 1;
			foreach (seen[k]) seen[k] = 1'b0;
			trail[0] = r * MAX_COLS + c;
			trail_len = 1;
			at_row = r;
			at_col = c;
			walk_idle = 1'b0;
			res.ev = EV_STARTED;
			res.next_row = 5'(r);
			res.next_col = 5'(c);
			return res;
		end
		if (walk_idle || trail_len == 0) begin
			walk_idle = 1'b1;
			res.ev = EV_FINISHED;
			res.next_row = 5'(at_row);
			res.next_col = 5'(at_col);
			return res;
		end
		r = at_row;
		c = at_col;
		seen[r * MAX_COLS + c] = 1'b1;
		order = '{int'(DIR_UP), int'(DIR_DOWN), int'(DIR_LEFT), int'(DIR_RIGHT)};
		pk[0] = int'(data[11:10]);
		pk[1] = (data[13:12] == 2'd3) ? 3 : int'(data[13:12]) + 1;
		pk[2] = 2 + int'(data[14]);
		for (int i = 0; i < 3; i++) begin
			t = order[i];
			order[i] = order[pk[i]];
			order[pk[i]] = t;
		end
		hit = 1'b0;
		for (int i = 0; i < 4 && !hit; i++) begin
			for (code = order[i]; code < 4; code++) begin
				nr = r;
				nc = c;
				wr = 2 * r + 1;
				wc = 2 * c + 1;
				case (code)
					DIR_UP: begin
						inb = (r >= 1);
						nr = r - 1;
						wr = 2 * r;
					end
					DIR_DOWN: begin
						inb = (r + 1 < rows);
						nr = r + 1;
						wr = 2 * r + 2;
					end
					DIR_LEFT: begin
						inb = (c >= 1);
						nc = c - 1;
						wc = 2 * c;
					end
					default: begin
						inb = (c + 1 < cols);
						nc = c + 1;
						wc = 2 * c + 2;
					end
				endcase
				if (!inb) break;
				if (!seen[nr * MAX_COLS + nc]) begin
					hit = 1'b1;
					at_row = nr;
					at_col = nc;
					if (trail_len < CELLS) begin
						trail[trail_len] = nr * MAX_COLS + nc;
						trail_len++;
					end
					res.ev = EV_ADVANCED;
					res.carved_row = 5'(r);
					res.carved_col = 5'(c);
					res.wall_row = 7'(wr);
					res.wall_col = 7'(wc);
					res.next_row = 5'(nr);
					res.next_col = 5'(nc);
					break;
				end
			end
		end
		if (hit) return res;
		trail_len--;
		res.carved_row = 5'(r);
		res.carved_col = 5'(c);
		if (trail_len == 0) begin
			walk_idle = 1'b1;
			res.ev = EV_FINISHED;
		end else begin
			t = trail[trail_len - 1];
			at_row = t / MAX_COLS;
			at_col = t % MAX_COLS;
			res.ev = EV_BACKTRACKED;
		end
		res.next_row = 5'(at_row);
		res.next_col = 5'(at_col);
		return res;
	endfunction

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		carve_t got;
		carve_t want;
		if (!arst_n) begin
			rows_reg = 6'd8;
			cols_reg = 6'd8;
			foreach (seen[k]) seen[k] = 1'b0;
			trail_len = 0;
			at_row = 0;
			at_col = 0;
			walk_idle = 1'b1;
			expected_q.delete();
			errors = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_GRID_ROWS) rows_reg = cfg_data;
				else cols_reg = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				expected_q.insert(expected_q.size(), carve_step(s_tuser[0], s_tdata));
			end
			if (m_tvalid && m_tready) begin
				got.ev = event_t'(m_tuser);
				got.carved_row = m_tdata[4:0];
				got.carved_col = m_tdata[9:5];
				got.wall_row = m_tdata[16:10];
				got.wall_col = m_tdata[23:17];
				got.next_row = m_tdata[28:24];
				got.next_col = m_tdata[33:29];
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual event %0d",
						$time, m_tuser);
					errors++;
				end else begin
					want = expected_q.pop_front();
					check_field("event_res", int'(want.ev), int'(got.ev));
					check_field("carved_row", int'(want.carved_row), int'(got.carved_row));
					check_field("carved_col", int'(want.carved_col), int'(got.carved_col));
					check_field("wall_row", int'(want.wall_row), int'(got.wall_row));
					check_field("wall_col", int'(want.wall_col), int'(got.wall_col));
					check_field("next_row", int'(want.next_row), int'(got.next_row));
					check_field("next_col", int'(want.next_col), int'(got.next_col));
				end
			end
			outstanding <= expected_q.size();
		end
	end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
module tb;
	import dmc_pkg::*;

	localparam int MAX_ROWS = 32;
	localparam int MAX_COLS = 32;
	localparam int QUIET_LIMIT = 4000;
	localparam int ITEM_GOAL = 900;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_idx;
	logic [5:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        calm = 1'b0;
	int          outstanding;
	int          errors;
	int          sent;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	dfs_maze_carver #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) i_dut (.*);

	maze_walk_checker #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) i_check (.*);

	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(0, 99) >= 7);
	end

	task automatic send(input logic kind, input int row, input int col,
		input int p0, input int p1, input int p2);
		while (!calm && $urandom_range(0, 99) < 7) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {1'b0, p2[0], p1[1:0], p0[1:0], col[4:0], row[4:0]};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
	endtask

	task automatic start_item(input int row, input int col);
		send(REQ_START, row, col, $urandom_range(0, 3), $urandom_range(0, 3),
			$urandom_range(0, 1));
	endtask

	task automatic step_item(input int p0, input int p1, input int p2);
		send(REQ_STEP, $urandom_range(0, 31), $urandom_range(0, 31), p0, p1, p2);
	endtask

	task automatic random_step();
		step_item($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 1));
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_grid(input logic [5:0] rows, input logic [5:0] cols);
		settle();
		cfg_we <= 1'b1;
		cfg_idx <= REG_GRID_ROWS;
		cfg_data <= rows;
		@(posedge clk);
		cfg_idx <= REG_GRID_COLS;
		cfg_data <= cols;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [5:0] pick_dim();
		case ($urandom_range(0, 9))
			0: return 6'd0;
			1: return 6'($urandom_range(33, 63));
			2: return 6'd32;
			3: return 6'd1;
			default: return 6'($urandom_range(2, 6));
		endcase
	endfunction

	function automatic int used_dim(logic [5:0] v, int limit);
		if (v == 0) return 1;
		if (int'(v) > limit) return limit;
		return int'(v);
	endfunction

	function automatic int pick_start(int limit);
		if ($urandom_range(0, 3) == 0) return $urandom_range(0, 31);
		return $urandom_range(0, limit - 1);
	endfunction

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
			else quiet++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		logic [5:0] rows;
		logic [5:0] cols;
		int er, ec, steps;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_GRID_ROWS;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= REQ_STEP;
		sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A step with no walk active, then a single cell grid from zero registers.
		step_item(0, 0, 0);
		set_grid(6'd0, 6'd0);
		start_item(5, 7);
		step_item(3, 3, 1);
		step_item(1, 2, 0);

		set_grid(6'd2, 6'd2);
		start_item(31, 31);
		step_item(3, 3, 1);
		step_item(0, 0, 0);
		step_item(2, 1, 1);
		step_item(1, 2, 0);
		step_item(3, 0, 1);
		step_item(0, 3, 0);
		step_item(2, 2, 1);
		step_item(1, 1, 0);

		set_grid(6'd63, 6'd33);
		start_item(31, 0);
		step_item(0, 0, 0);
		step_item(3, 3, 1);
		step_item(1, 2, 1);
		start_item(0, 31);
		step_item(2, 1, 0);
		step_item(0, 3, 1);

		set_grid(6'd1, 6'd32);
		start_item(0, 31);
		step_item(3, 0, 0);
		step_item(0, 1, 1);

		// Random walks; some phases change the grid under a walk in progress.
		while (sent < ITEM_GOAL) begin
			rows = pick_dim();
			cols = pick_dim();
			set_grid(rows, cols);
			calm <= (sent >= 350 && sent < 500);
			er = used_dim(rows, MAX_ROWS);
			ec = used_dim(cols, MAX_COLS);
			if ($urandom_range(0, 3) != 0) start_item(pick_start(er), pick_start(ec));
			steps = $urandom_range(40, 120);
			if (2 * er * ec + 4 < steps) steps = 2 * er * ec + 4;
			if (ITEM_GOAL - sent < steps) steps = ITEM_GOAL - sent;
			repeat (steps) begin
				if ($urandom_range(0, 99) < 3) start_item(pick_start(er), pick_start(ec));
				else random_step();
			end
		end

		settle();
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
